>>> hw/rtl/ids_pkg.sv
package ids_pkg;

  localparam int unsigned OP_BITS = 3;

  // request codes carried on in_tuser
  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_CLEAR      = 3'd6
  } ids_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } ids_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_RDWAIT,
    S_RESP
  } ids_state_t;

endpackage

>>> hw/rtl/indexed_deque_store_top.sv
// sequence: push, pop, clear, unused and refused requests go from S_EXEC straight to S_RESP;
//   a read passes S_EXEC, S_RDWAIT and S_RESP; an insert or append passes S_EXEC, S_SHIFT and S_RESP
// requests: one at a time, a new request is taken only once the result has been accepted;
//   the insert shift moves one word per cycle through the read port and the write port of the store
// reset: synchronous active-low rst_n empties the sequence (count and front slot to zero);
//   store contents are not cleared, since only positions already written are ever read
module indexed_deque_store_top
  import ids_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,

  // request channel
  input  logic                                                 in_tvalid,
  output logic                                                 in_tready,
  // item_value, position (zero padded to bytes)
  input  logic [((WORD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] in_tdata,
  // operation
  input  logic [OP_BITS-1:0]                                   in_tuser,

  // result channel
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  // read_value, item_count, status (zero padded to bytes)
  output logic [((WORD_BITS + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0] out_tdata
);

  // count and position width, store address width
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OUT_W = ((WORD_BITS + CW + 2 + 7) / 8) * 8;

  // sequencer and sequence state
  ids_state_t           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        front_r, front_nxt;

  // captured request
  ids_op_t              op_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CW-1:0]        pos_r;

  // insert shift walker: idx_r is the destination position of the next move,
  // mv_r marks a word read last cycle that must be written to dst_r now
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        dst_r, dst_nxt;
  logic                 mv_r, mv_nxt;

  // result register
  logic [WORD_BITS-1:0] rdv_r, rdv_nxt;
  ids_status_t          status_r, status_nxt;

  // store port
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 full;
  logic [AW-1:0]        front_dec;

  // store slot of a position: front plus position, wrapped once
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                            input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW + 1)'(front) + (CW + 1)'(p);
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ids_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign full      = (cnt_r == CW'(DEPTH));
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);

  // handshakes: one request in flight, the result waits in its register
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign out_tdata  = OUT_W'({status_r, cnt_r, rdv_r});

  // capture the request transaction
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= ids_op_t'(in_tuser);
      word_r <= in_tdata[WORD_BITS-1:0];
      pos_r  <= in_tdata[WORD_BITS +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      front_r <= '0;
      mv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      front_r <= front_nxt;
      mv_r    <= mv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    dst_r    <= dst_nxt;
    rdv_r    <= rdv_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    front_nxt  = front_r;
    idx_nxt    = idx_r;
    dst_nxt    = dst_r;
    mv_nxt     = mv_r;
    rdv_nxt    = rdv_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = slot_of(front_r, cnt_r);
    ram_wdata  = word_r;
    ram_re     = 1'b0;
    ram_raddr  = slot_of(front_r, pos_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end

      // decode the request: run push, pop and clear here, start a read or an insert
      S_EXEC: begin
        rdv_nxt    = '0;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        unique case (op_r)
          OP_PUSH_BACK: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_PUSH_FRONT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              front_nxt = front_dec;
              cnt_nxt   = cnt_r + CW'(1);
            end
          end
          OP_POP_BACK: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              front_nxt = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
              cnt_nxt   = cnt_r - CW'(1);
            end
          end
          OP_READ: begin
            if (pos_r >= cnt_r) begin
              status_nxt = ST_RANGE;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          OP_INSERT: begin
            // range check ahead of the full check; position == count appends
            if (pos_r > cnt_r) begin
              status_nxt = ST_RANGE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              idx_nxt   = cnt_r;
              mv_nxt    = 1'b0;
              state_nxt = S_SHIFT;
            end
          end
          OP_CLEAR: begin
            cnt_nxt   = '0;
            front_nxt = '0;
          end
          default: begin
            // unused code leaves everything as it is
          end
        endcase
      end

      // move words toward the back, one per cycle, from the back end down
      S_SHIFT: begin
        if (mv_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (idx_r > pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(front_r, idx_r - CW'(1));
          dst_nxt   = slot_of(front_r, idx_r);
          mv_nxt    = 1'b1;
          idx_nxt   = idx_r - CW'(1);
        end else if (mv_r) begin
          mv_nxt = 1'b0;
        end else begin
          // last move is done, drop the new word into its place
          ram_we    = 1'b1;
          ram_waddr = slot_of(front_r, pos_r);
          ram_wdata = word_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RDWAIT: begin
        rdv_nxt   = ram_rdata;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // the sequence never holds more than the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("count above store depth");

  // front slot stays inside the store
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= AW'(DEPTH - 1))
    else $error("front slot outside store");

  // no new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while result pending");

  // the shift walker never passes the insert position
  a_shift_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_r >= pos_r))
    else $error("insert shift ran past its position");

  // a store write during a shift never hits the slot being read
  a_shift_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("shift read and write collide");

endmodule

>>> hw/rtl/ids_ram.sv
module ids_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
